// ===== rtl/core/rational_arith_unit_assert.svh =====
// Assertion macros for the rational arithmetic unit.
`ifndef RATIONAL_ARITH_UNIT_ASSERT_SVH
`define RATIONAL_ARITH_UNIT_ASSERT_SVH

// Checks that a property holds at every clock edge outside reset.
`define RAU_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checks that a condition implies another in the following cycle.
`define RAU_ASSERT_NEXT(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/core/rau_pkg.sv =====
`timescale 1ns / 1ps

package rau_pkg;

    localparam int unsigned OPERAND_WIDTH_DEFAULT = 32;

    localparam logic [1:0] ACT_ADD = 2'd0;
    localparam logic [1:0] ACT_SUB = 2'd1;
    localparam logic [1:0] ACT_MUL = 2'd2;
    localparam logic [1:0] ACT_DIV = 2'd3;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_ZERO_DEN = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_D,
        ST_COMBINE,
        ST_GCD,
        ST_DIV_N,
        ST_DIV_D,
        ST_CHECK,
        ST_OUT
    } state_t;

endpackage

// ===== rtl/core/rational_arith_unit.sv =====
`timescale 1ns / 1ps

// Rational arithmetic unit: adds, subtracts, multiplies or divides two signed
// fractions and returns the result in lowest terms with a positive denominator.
// One transfer is processed at a time. Up to three cross products are formed
// on a shared OPERAND_WIDTH x OPERAND_WIDTH multiplier. The greatest common
// divisor is found by a binary loop that does one subtract or shift per
// cycle. The numerator and the denominator are then divided by it with a
// restoring divider at one quotient bit per cycle.
// After the products come the combine step, the divisor search, the two
// divisions, the check and the output. Zero denominator products and zero
// numerators skip the search and the divisions.
// A zero denominator product yields status 1, a result that does not fit the
// operand width yields status 2; both return zero over one.

`include "rational_arith_unit_assert.svh"

module rational_arith_unit #(
    parameter int unsigned OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_action,
    input  logic signed [31:0] s_left_num,
    input  logic signed [31:0] s_left_den,
    input  logic signed [31:0] s_right_num,
    input  logic signed [31:0] s_right_den,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_result_num,
    output logic [30:0]        m_result_den,
    output logic [1:0]         m_status
);

    localparam int unsigned W  = OPERAND_WIDTH;
    localparam int unsigned DW = 2 * OPERAND_WIDTH + 1;
    localparam int unsigned CW = $clog2(DW + 1);

    rau_pkg::state_t state_reg, state_next;

    logic [1:0]    act_reg;
    logic [W-1:0]  ln_reg, ld_reg, rn_reg, rd_reg;
    logic          lnn_reg, ldn_reg, rnn_reg, rdn_reg;
    logic [DW-1:0] a_reg, b_reg, dm_reg;
    logic [DW-1:0] nm_reg, nm_next;
    logic          ns_reg, ns_next;
    logic [DW-1:0] ga_reg, ga_next, gb_reg, gb_next;
    logic [CW-1:0] gk_reg, gk_next;
    logic [DW-1:0] quo_reg, quo_next, rem_reg, rem_next, dvd_reg, dvd_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] g_reg, g_next;
    logic [DW-1:0] qn_reg, qn_next;
    logic          busy_div;

    logic signed [31:0] out_num_reg, out_num_next;
    logic [30:0]        out_den_reg, out_den_next;
    logic [1:0]         out_status_reg, out_status_next;
    logic               m_valid_reg, m_valid_next;

    logic [W-1:0]      mul_x, mul_y;
    logic [2*W-1:0]    mul_p;
    logic [DW-1:0]     rem_shift, rem_sub;
    logic              sa, sb, ds;
    logic [DW-1:0]     limit;

    function automatic logic [W-1:0] mag(input logic [31:0] v);
        logic [W-1:0] x;
        x = v[W-1:0];
        return x[W-1] ? (~x + {{(W-1){1'b0}}, 1'b1}) : x;
    endfunction

    assign mul_p = {{W{1'b0}}, mul_x} * {{W{1'b0}}, mul_y};

    always_comb begin
        mul_x = ln_reg;
        mul_y = rd_reg;
        case (state_reg)
            rau_pkg::ST_MUL_A: begin
                mul_x = ln_reg;
                mul_y = (act_reg == rau_pkg::ACT_MUL) ? rn_reg : rd_reg;
            end
            rau_pkg::ST_MUL_B: begin
                mul_x = rn_reg;
                mul_y = ld_reg;
            end
            rau_pkg::ST_MUL_D: begin
                mul_x = ld_reg;
                mul_y = (act_reg == rau_pkg::ACT_DIV) ? rn_reg : rd_reg;
            end
            default: begin
                mul_x = ln_reg;
                mul_y = rd_reg;
            end
        endcase
    end

    assign sa = (act_reg == rau_pkg::ACT_MUL) ? (lnn_reg ^ rnn_reg) : (lnn_reg ^ rdn_reg);
    assign sb = (rnn_reg ^ ldn_reg) ^ (act_reg == rau_pkg::ACT_SUB);
    assign ds = (act_reg == rau_pkg::ACT_DIV) ? (ldn_reg ^ rnn_reg) : (ldn_reg ^ rdn_reg);
    assign limit = {{(DW-W+1){1'b0}}, 1'b1, {(W-2){1'b0}}} << 1;

    assign rem_shift = {rem_reg[DW-2:0], dvd_reg[DW-1]};
    assign rem_sub   = rem_shift - g_reg;
    assign busy_div  = (state_reg == rau_pkg::ST_DIV_N) || (state_reg == rau_pkg::ST_DIV_D);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rau_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == rau_pkg::ST_IDLE && s_valid) begin
            act_reg <= s_action;
            ln_reg  <= mag(s_left_num);
            ld_reg  <= mag(s_left_den);
            rn_reg  <= mag(s_right_num);
            rd_reg  <= mag(s_right_den);
            lnn_reg <= s_left_num[W-1];
            ldn_reg <= s_left_den[W-1];
            rnn_reg <= s_right_num[W-1];
            rdn_reg <= s_right_den[W-1];
        end
        if (state_reg == rau_pkg::ST_MUL_A) begin
            a_reg <= {1'b0, mul_p};
        end
        if (state_reg == rau_pkg::ST_MUL_B) begin
            b_reg <= {1'b0, mul_p};
        end
        if (state_reg == rau_pkg::ST_MUL_D) begin
            dm_reg <= {1'b0, mul_p};
        end
        nm_reg         <= nm_next;
        ns_reg         <= ns_next;
        ga_reg         <= ga_next;
        gb_reg         <= gb_next;
        gk_reg         <= gk_next;
        g_reg          <= g_next;
        quo_reg        <= quo_next;
        rem_reg        <= rem_next;
        dvd_reg        <= dvd_next;
        cnt_reg        <= cnt_next;
        qn_reg         <= qn_next;
        out_num_reg    <= out_num_next;
        out_den_reg    <= out_den_next;
        out_status_reg <= out_status_next;
    end

    always_comb begin
        state_next      = state_reg;
        m_valid_next    = m_valid_reg;
        nm_next         = nm_reg;
        ns_next         = ns_reg;
        ga_next         = ga_reg;
        gb_next         = gb_reg;
        gk_next         = gk_reg;
        g_next          = g_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        dvd_next        = dvd_reg;
        cnt_next        = cnt_reg;
        qn_next         = qn_reg;
        out_num_next    = out_num_reg;
        out_den_next    = out_den_reg;
        out_status_next = out_status_reg;
        s_ready         = 1'b0;
        if (busy_div) begin
            if (rem_shift >= g_reg) begin
                rem_next = rem_sub;
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end else begin
                rem_next = rem_shift;
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            dvd_next = {dvd_reg[DW-2:0], 1'b0};
            cnt_next = cnt_reg - {{(CW-1){1'b0}}, 1'b1};
        end
        case (state_reg)
            rau_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = rau_pkg::ST_MUL_A;
                end
            end
            rau_pkg::ST_MUL_A: begin
                state_next = (act_reg == rau_pkg::ACT_ADD || act_reg == rau_pkg::ACT_SUB)
                             ? rau_pkg::ST_MUL_B : rau_pkg::ST_MUL_D;
            end
            rau_pkg::ST_MUL_B: begin
                state_next = rau_pkg::ST_MUL_D;
            end
            rau_pkg::ST_MUL_D: begin
                state_next = rau_pkg::ST_COMBINE;
            end
            rau_pkg::ST_COMBINE: begin
                if (act_reg == rau_pkg::ACT_ADD || act_reg == rau_pkg::ACT_SUB) begin
                    if (sa == sb) begin
                        nm_next = a_reg + b_reg;
                        ns_next = sa;
                    end else if (a_reg >= b_reg) begin
                        nm_next = a_reg - b_reg;
                        ns_next = sa;
                    end else begin
                        nm_next = b_reg - a_reg;
                        ns_next = sb;
                    end
                end else begin
                    nm_next = a_reg;
                    ns_next = sa;
                end
                ga_next = nm_next;
                gb_next = dm_reg;
                gk_next = '0;
                if (dm_reg == '0) begin
                    out_num_next    = '0;
                    out_den_next    = 31'd1;
                    out_status_next = rau_pkg::STATUS_ZERO_DEN;
                    m_valid_next    = 1'b1;
                    state_next      = rau_pkg::ST_OUT;
                end else if (nm_next == '0) begin
                    out_num_next    = '0;
                    out_den_next    = 31'd1;
                    out_status_next = rau_pkg::STATUS_OK;
                    m_valid_next    = 1'b1;
                    state_next      = rau_pkg::ST_OUT;
                end else begin
                    state_next = rau_pkg::ST_GCD;
                end
            end
            rau_pkg::ST_GCD: begin
                if (ga_reg == gb_reg) begin
                    g_next   = ga_reg << gk_reg;
                    rem_next = '0;
                    dvd_next = nm_reg;
                    cnt_next = CW'(DW);
                    state_next = rau_pkg::ST_DIV_N;
                end else if (!ga_reg[0] && !gb_reg[0]) begin
                    ga_next = ga_reg >> 1;
                    gb_next = gb_reg >> 1;
                    gk_next = gk_reg + {{(CW-1){1'b0}}, 1'b1};
                end else if (!ga_reg[0]) begin
                    ga_next = ga_reg >> 1;
                end else if (!gb_reg[0]) begin
                    gb_next = gb_reg >> 1;
                end else if (ga_reg > gb_reg) begin
                    ga_next = (ga_reg - gb_reg) >> 1;
                end else begin
                    gb_next = (gb_reg - ga_reg) >> 1;
                end
            end
            rau_pkg::ST_DIV_N: begin
                if (cnt_reg == {{(CW-1){1'b0}}, 1'b1}) begin
                    qn_next  = quo_next;
                    rem_next = '0;
                    dvd_next = dm_reg;
                    cnt_next = CW'(DW);
                    state_next = rau_pkg::ST_DIV_D;
                end
            end
            rau_pkg::ST_DIV_D: begin
                if (cnt_reg == {{(CW-1){1'b0}}, 1'b1}) begin
                    state_next = rau_pkg::ST_CHECK;
                end
            end
            rau_pkg::ST_CHECK: begin
                m_valid_next = 1'b1;
                state_next   = rau_pkg::ST_OUT;
                if (quo_reg > limit - {{(DW-1){1'b0}}, 1'b1} ||
                    ((ns_reg ^ ds) ? (qn_reg > limit)
                                   : (qn_reg > limit - {{(DW-1){1'b0}}, 1'b1}))) begin
                    out_num_next    = '0;
                    out_den_next    = 31'd1;
                    out_status_next = rau_pkg::STATUS_OVERFLOW;
                end else begin
                    out_num_next    = (ns_reg ^ ds) ? (32'd0 - 32'(qn_reg)) : 32'(qn_reg);
                    out_den_next    = 31'(quo_reg);
                    out_status_next = rau_pkg::STATUS_OK;
                end
            end
            rau_pkg::ST_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    state_next   = rau_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rau_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid      = m_valid_reg;
    assign m_result_num = out_num_reg;
    assign m_result_den = out_den_reg;
    assign m_status     = out_status_reg;

    `RAU_ASSERT(a_ready_idle, aclk, aresetn, !(s_ready && m_valid), "ready while result pending")
    `RAU_ASSERT(a_den_pos, aclk, aresetn,
                !m_valid || (m_result_den != 31'd0), "zero result denominator")
    `RAU_ASSERT(a_err_zero, aclk, aresetn,
                !m_valid || m_status == rau_pkg::STATUS_OK ||
                (m_result_num == 32'sd0 && m_result_den == 31'd1),
                "error result not zero over one")
    `RAU_ASSERT_NEXT(a_start, aclk, aresetn, s_valid && s_ready, state_reg == rau_pkg::ST_MUL_A, "accepted item did not start")

endmodule
